FILE: rtl/core/rmedf_pkg.sv
package rmedf_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 2'd1;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_LOAD    = 2'd1,
		MODE_READ    = 2'd2,
		MODE_RESTART = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  task_index;
		logic [15:0] period;
		logic [15:0] burst;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  running_task;
		logic        idle;
		logic        finished;
		logic        missed;
		logic [4:0]  released_misses;
		logic [31:0] lost_count;
		logic [31:0] complete_count;
	} result_t;

endpackage

FILE: rtl/core/rmedf_task_mem.sv
module rmedf_task_mem #(
	parameter int WIDTH = 144,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/rm_edf_tick_scheduler.sv
// Periodic task scheduler, one item per start pulse, result strobed on done for one cycle
// and never held back. The task table sits in a single-port-write, single-read memory with
// a registered read, so a tick walks the entries in use (task_count, capped at MAX_TASKS)
// one per cycle, and a restart walks them the same way. busy stays high until the done
// cycle has passed; configuration writes are taken at any time but belong to idle periods.
module rm_edf_tick_scheduler import rmedf_pkg::*; #(
	parameter int MAX_TASKS  = 16,
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  in_item_t              item,
	output logic                  busy,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef struct packed {
		logic [15:0]           period;
		logic [15:0]           burst;
		logic [15:0]           remaining;
		logic [TIME_WIDTH-1:0] deadline;
		logic [31:0]           lost;
		logic [31:0]           complete;
	} row_t;

	localparam int RW = $bits(row_t);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SWEEP = 7'b0000010,
		ST_PICK  = 7'b0000100,
		ST_RUN1  = 7'b0001000,
		ST_RUN2  = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                state_q;
	logic                  policy_q;
	logic [4:0]            task_count_q;
	logic [TIME_WIDTH-1:0] time_q;
	logic [CW-1:0]         cnt_q;
	logic                  vld_s1;
	logic [IW-1:0]         addr_s1;
	logic                  restart_q;
	logic                  found_q;
	logic [IW-1:0]         pick_q;
	logic [15:0]           best_per_q;
	logic [TIME_WIDTH-1:0] best_dl_q;
	logic [4:0]            rel_q;
	row_t                  row_s2;
	logic                  run_s2;
	logic                  fin_s2;
	result_t               result_q;

	logic [CW-1:0]         n_used;
	logic                  idx_ok;
	row_t                  rd_row;
	logic [RW-1:0]         mem_rd_data;
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	row_t                  mem_wdata;
	logic                  mem_re;
	logic [IW-1:0]         mem_raddr;
	row_t                  load_row;
	logic [TIME_WIDTH-1:0] rd_per_w;
	logic                  rdy;
	logic                  take;
	logic                  lapse;
	row_t                  sweep_row;
	row_t                  r1;
	logic                  run1;
	logic                  fin1;
	row_t                  r2;
	logic                  miss2;
	logic                  sweep_rd;

	rmedf_task_mem #(
		.WIDTH(RW),
		.DEPTH(MAX_TASKS)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (mem_re),
		.rd_addr(mem_raddr),
		.rd_data(mem_rd_data)
	);

	assign rd_row    = row_t'(mem_rd_data);
	assign busy      = (state_q != ST_IDLE);
	assign done      = (state_q == ST_DONE);
	assign result    = result_q;
	assign cfg_ready = 1'b1;
	assign idx_ok    = (32'(item.task_index) < MAX_TASKS);
	assign sweep_rd  = (cnt_q < n_used);

	always_comb begin
		if (32'(task_count_q) > MAX_TASKS) begin
			n_used = CW'(MAX_TASKS);
		end else begin
			n_used = CW'(task_count_q);
		end
	end

	always_comb begin
		load_row.period    = item.period;
		load_row.burst     = item.burst;
		load_row.remaining = item.burst;
		load_row.deadline  = TIME_WIDTH'(item.period);
		load_row.lost      = '0;
		load_row.complete  = '0;
	end

	// selection looks at the entry before its release check
	always_comb begin
		rd_per_w = TIME_WIDTH'(rd_row.period);
		rdy = (rd_row.remaining != 16'd0) &&
			((rd_row.deadline <= rd_per_w) || (time_q >= rd_row.deadline - rd_per_w));
		if (!found_q) begin
			take = rdy;
		end else if (policy_q) begin
			take = rdy && (rd_row.deadline <= best_dl_q);
		end else begin
			take = rdy && (rd_row.period < best_per_q);
		end
		lapse = (time_q >= rd_row.deadline);
		sweep_row = rd_row;
		if (restart_q) begin
			sweep_row.remaining = rd_row.burst;
			sweep_row.deadline  = rd_per_w;
			sweep_row.lost      = '0;
			sweep_row.complete  = '0;
		end else if (lapse) begin
			sweep_row.deadline  = rd_row.deadline + rd_per_w;
			sweep_row.remaining = rd_row.burst;
			sweep_row.lost      = rd_row.lost + 32'd1;
		end
	end

	// run, first half: spend one unit, finish the burst
	always_comb begin
		r1   = rd_row;
		run1 = (rd_row.remaining != 16'd0);
		fin1 = 1'b0;
		if (run1) begin
			r1.remaining = rd_row.remaining - 16'd1;
			if (rd_row.remaining == 16'd1) begin
				r1.complete  = rd_row.complete + 32'd1;
				r1.deadline  = rd_row.deadline + rd_per_w;
				r1.remaining = rd_row.burst;
				fin1         = 1'b1;
			end
		end
	end

	// run, second half: late check against the deadline
	always_comb begin
		r2    = row_s2;
		miss2 = 1'b0;
		if (run_s2 && (row_s2.remaining != 16'd0) &&
			((row_s2.deadline == '0) ||
			(time_q >= row_s2.deadline - TIME_WIDTH'(1)))) begin
			r2.lost      = row_s2.lost + 32'd1;
			r2.deadline  = row_s2.deadline + TIME_WIDTH'(row_s2.period);
			r2.remaining = row_s2.burst;
			miss2        = 1'b1;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = load_row;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (start && idx_ok) begin
					mem_we    = (item.mode == MODE_LOAD);
					mem_waddr = IW'(item.task_index);
					mem_re    = (item.mode == MODE_READ);
					mem_raddr = IW'(item.task_index);
				end
			end
			ST_SWEEP: begin
				mem_re    = sweep_rd;
				mem_raddr = cnt_q[IW-1:0];
				mem_we    = vld_s1;
				mem_waddr = addr_s1;
				mem_wdata = sweep_row;
			end
			ST_PICK: begin
				mem_re    = found_q;
				mem_raddr = pick_q;
			end
			ST_RUN2: begin
				mem_we    = run_s2;
				mem_waddr = pick_q;
				mem_wdata = r2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= 1'b0;
			task_count_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLICY:     policy_q <= cfg_data[0];
				REG_TASK_COUNT: task_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			time_q    <= '0;
			vld_s1    <= 1'b0;
			restart_q <= 1'b0;
			found_q   <= 1'b0;
			run_s2    <= 1'b0;
			cnt_q     <= '0;
			rel_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						result_q <= '{running_task: '0, idle: 1'b1, finished: 1'b0,
							missed: 1'b0, released_misses: '0, lost_count: '0,
							complete_count: '0};
						cnt_q         <= '0;
						vld_s1        <= 1'b0;
						found_q       <= 1'b0;
						rel_q         <= '0;
						case (item.mode)
							MODE_TICK: begin
								restart_q <= 1'b0;
								state_q   <= ST_SWEEP;
							end
							MODE_RESTART: begin
								restart_q <= 1'b1;
								time_q    <= '0;
								state_q   <= ST_SWEEP;
							end
							MODE_READ: begin
								state_q <= idx_ok ? ST_READ : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					if (sweep_rd) begin
						cnt_q <= CW'(cnt_q + 1'b1);
					end
					vld_s1  <= sweep_rd;
					addr_s1 <= cnt_q[IW-1:0];
					if (vld_s1 && !restart_q) begin
						if (take) begin
							found_q    <= 1'b1;
							pick_q     <= addr_s1;
							best_per_q <= rd_row.period;
							best_dl_q  <= rd_row.deadline;
						end
						if (lapse) begin
							rel_q <= rel_q + 5'd1;
						end
					end
					if (!sweep_rd && !vld_s1) begin
						state_q <= restart_q ? ST_DONE : ST_PICK;
					end
				end
				ST_PICK: begin
					result_q.released_misses <= rel_q;
					if (found_q) begin
						state_q <= ST_RUN1;
					end else begin
						time_q  <= time_q + TIME_WIDTH'(1);
						state_q <= ST_DONE;
					end
				end
				ST_RUN1: begin
					row_s2  <= r1;
					run_s2  <= run1;
					fin_s2  <= fin1;
					state_q <= ST_RUN2;
				end
				ST_RUN2: begin
					result_q.running_task <= 4'(pick_q);
					result_q.idle         <= 1'b0;
					result_q.finished     <= fin_s2;
					result_q.missed       <= miss2;
					time_q                <= time_q + TIME_WIDTH'(1);
					state_q               <= ST_DONE;
				end
				ST_READ: begin
					result_q.lost_count     <= rd_row.lost;
					result_q.complete_count <= rd_row.complete;
					state_q                 <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
